// ----- src/jvts_pkg.sv -----
`default_nettype none

package jvts_pkg;

    // Fixed payload geometry
    localparam int MAXJ       = 7;
    localparam int POS_W      = 32;
    localparam int TIME_W     = 48;
    localparam int MAX_FRAC   = 24;
    localparam int QX_W       = POS_W + MAX_FRAC;
    localparam int CFG_IDX_W  = 3;
    localparam int S_TDATA_W  = MAXJ * POS_W;
    localparam int M_TDATA_W  = MAXJ * POS_W + TIME_W;
    localparam int M_TUSER_W  = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [QX_W-1:0]   VEL_POS_MAX = QX_W'(32'h7FFF_FFFF);
    localparam logic [QX_W-1:0]   VEL_NEG_MAX = QX_W'(33'h0_8000_0000);

    // Item kinds carried on the slave tuser
    localparam logic CMD_START    = 1'b0;
    localparam logic CMD_WAYPOINT = 1'b1;

    // Bits of the master tuser
    localparam int TU_ZERO_MOVE = 0;
    localparam int TU_SATURATED = 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DUR   = 5'b00010,
        S_CHECK = 5'b00100,
        S_VEL   = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    // Status of the shared divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ----- src/joint_velocity_time_scaler_core.sv -----
// Joint velocity time scaler.
// Slave stream: one waypoint item per handshake; tdata holds seven signed
// Q.F joint positions, tuser selects a start point (0) or a waypoint (1).
// A start point stores the positions and clears elapsed time, and gives no
// item. A waypoint gives one master item: seven signed Q.F velocities plus
// the 48-bit elapsed time in tdata, zero_move and saturated flags in tuser.
// Config channel: writes velocity limit i at index i; indexes past the
// used joints are dropped. Write only while the block is idle.
// A waypoint runs JOINTS divisions, one per joint, for the segment duration
// through one shared restoring divider, then JOINTS more for the velocities
// if any joint moves (none for a segment with no motion), plus a check step
// and an output load. s_axis_tready is low for the whole run, so the next
// waypoint is accepted only once this one has been loaded for output.
// A finished item sits in the output register; while the receiver stalls,
// the next item may be accepted and computed, and waits before its result
// is loaded. Reset clears stored positions and time, sets all limits to 1.0
// and drops any pending output item.
`default_nettype none

module joint_velocity_time_scaler_core #(
    parameter int JOINTS    = 7,
    parameter int FRAC_BITS = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // tdata: joint_pos_0 [31:0] .. joint_pos_6 [223:192]
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire  [jvts_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    // tuser: cmd [0]
    input  wire                                   s_axis_tuser,
    // tdata: joint_vel_0 [31:0] .. joint_vel_6 [223:192], elapsed [271:224]
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    output logic [jvts_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    // tuser: zero_move [0], saturated [1]
    output logic [jvts_pkg::M_TUSER_W-1:0]        m_axis_tuser,
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire  [jvts_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire  [jvts_pkg::POS_W-1:0]            i_cfg_data
);
    import jvts_pkg::*;

    localparam int IDX_W = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int NUM_W = POS_W + FRAC_BITS;

    t_state                r_state;
    logic [IDX_W-1:0]      r_idx;
    logic                  r_div_start;
    logic [POS_W-1:0]      r_qd_max [JOINTS];
    logic [POS_W-1:0]      r_prev   [JOINTS];
    logic [POS_W-1:0]      r_mag    [JOINTS];
    logic                  r_neg    [JOINTS];
    logic [POS_W-1:0]      r_vel    [JOINTS];
    logic [TIME_W-1:0]     r_dur;
    logic [TIME_W-1:0]     r_elapsed;
    logic                  r_moving;
    logic                  r_sat;
    logic                  r_out_valid;
    logic [M_TDATA_W-1:0]  r_out_data;
    logic [M_TUSER_W-1:0]  r_out_user;

    logic                  in_acc;
    logic                  last_joint;
    logic [POS_W-1:0]      lim;
    logic [NUM_W-1:0]      div_num;
    logic [TIME_W-1:0]     div_den;
    t_div_stat             div_stat;
    logic [NUM_W-1:0]      div_quot;
    logic [QX_W-1:0]       quot_x;
    logic [POS_W-1:0]      n_mag [JOINTS];
    logic                  n_neg [JOINTS];
    logic                  n_moving;
    logic                  n_div_start;
    logic [TIME_W:0]       time_sum;
    logic [TIME_W-1:0]     n_elapsed;
    logic                  n_time_sat;
    logic                  out_free;
    logic [M_TDATA_W-1:0]  n_out_data;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign last_joint    = (r_idx == IDX_W'(JOINTS - 1));
    assign out_free      = !r_out_valid || m_axis_tready;

    // Per-joint delta magnitude and sign against the stored position
    always_comb begin
        n_moving = 1'b0;
        for (int k = 0; k < JOINTS; k++) begin
            logic [POS_W:0] d;
            d = {s_axis_tdata[k*POS_W+POS_W-1], s_axis_tdata[k*POS_W +: POS_W]}
                - {r_prev[k][POS_W-1], r_prev[k]};
            n_neg[k] = d[POS_W];
            n_mag[k] = d[POS_W] ? POS_W'(-d) : d[POS_W-1:0];
            if (n_mag[k] != '0)
                n_moving = 1'b1;
        end
    end

    // Divider operand select: limit pass, then velocity pass
    always_comb begin
        lim     = (r_qd_max[r_idx] == '0) ? POS_W'(1) : r_qd_max[r_idx];
        div_num = {r_mag[r_idx], {FRAC_BITS{1'b0}}};
        div_den = (r_state == S_VEL) ? r_dur : TIME_W'(lim);
        quot_x  = QX_W'(div_quot);
    end

    // Divide launch: first joint on acceptance or after the check step, next joint on each done
    always_comb begin
        case (r_state)
            S_IDLE:  n_div_start = in_acc && (s_axis_tuser == CMD_WAYPOINT);
            S_DUR,
            S_VEL:   n_div_start = div_stat.done && !last_joint;
            S_CHECK: n_div_start = r_moving;
            default: n_div_start = 1'b0;
        endcase
    end

    jvts_div #(
        .NUM_W (NUM_W),
        .DEN_W (TIME_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // Saturating elapsed-time update
    always_comb begin
        time_sum   = {1'b0, r_elapsed} + {1'b0, r_dur};
        n_time_sat = r_moving && time_sum[TIME_W];
        if (!r_moving)
            n_elapsed = r_elapsed;
        else if (time_sum[TIME_W])
            n_elapsed = TIME_MAX;
        else
            n_elapsed = time_sum[TIME_W-1:0];
    end

    // Result packing; unused joints read as zero
    always_comb begin
        n_out_data = '0;
        for (int k = 0; k < JOINTS; k++)
            n_out_data[k*POS_W +: POS_W] = r_vel[k];
        n_out_data[MAXJ*POS_W +: TIME_W] = n_elapsed;
    end

    // Velocity limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < JOINTS; k++)
                r_qd_max[k] <= POS_W'(1) << FRAC_BITS;
        end else if (i_cfg_valid && (32'(i_cfg_index) < JOINTS)) begin
            r_qd_max[i_cfg_index[IDX_W-1:0]] <= i_cfg_data;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_div_start <= 1'b0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < JOINTS; k++)
                r_prev[k] <= '0;
        end else begin
            r_div_start <= n_div_start;
            if (r_state == S_FIN && out_free)
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        for (int k = 0; k < JOINTS; k++)
                            r_prev[k] <= s_axis_tdata[k*POS_W +: POS_W];
                        if (s_axis_tuser == CMD_START) begin
                            r_elapsed <= '0;
                        end else begin
                            r_idx   <= '0;
                            r_state <= S_DUR;
                        end
                    end
                end
                S_DUR: begin
                    if (div_stat.done) begin
                        if (last_joint) begin
                            r_state <= S_CHECK;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_CHECK: begin
                    if (r_moving) begin
                        r_idx   <= '0;
                        r_state <= S_VEL;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_VEL: begin
                    if (div_stat.done) begin
                        if (last_joint) begin
                            r_state <= S_FIN;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_elapsed <= n_elapsed;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Per-item working registers
    always_ff @(posedge i_clk) begin
        if (in_acc && (s_axis_tuser == CMD_WAYPOINT)) begin
            r_dur    <= '0;
            r_sat    <= 1'b0;
            r_moving <= n_moving;
            for (int k = 0; k < JOINTS; k++) begin
                r_mag[k] <= n_mag[k];
                r_neg[k] <= n_neg[k];
                r_vel[k] <= '0;
            end
        end else if (r_state == S_DUR && div_stat.done) begin
            // Segment duration: largest per-joint time, clipped to 48 bits
            if (quot_x > QX_W'(TIME_MAX)) begin
                r_sat <= 1'b1;
                r_dur <= TIME_MAX;
            end else if (quot_x[TIME_W-1:0] > r_dur) begin
                r_dur <= quot_x[TIME_W-1:0];
            end
        end else if (r_state == S_CHECK && r_moving && r_dur == '0) begin
            // Motion too small to register: one LSB of time
            r_dur <= TIME_W'(1);
            r_sat <= 1'b1;
        end else if (r_state == S_VEL && div_stat.done) begin
            if (r_neg[r_idx]) begin
                if (quot_x > VEL_NEG_MAX) begin
                    r_sat        <= 1'b1;
                    r_vel[r_idx] <= POS_W'(-VEL_NEG_MAX);
                end else begin
                    r_vel[r_idx] <= POS_W'(-quot_x);
                end
            end else begin
                if (quot_x > VEL_POS_MAX) begin
                    r_sat        <= 1'b1;
                    r_vel[r_idx] <= VEL_POS_MAX[POS_W-1:0];
                end else begin
                    r_vel[r_idx] <= quot_x[POS_W-1:0];
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && out_free) begin
            r_out_data               <= n_out_data;
            r_out_user[TU_ZERO_MOVE] <= !r_moving;
            r_out_user[TU_SATURATED] <= r_sat || n_time_sat;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // The divider is never running while new items are taken
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_stat.busy)
        else $error("divider busy while idle");

    // Joint index stays within the used joints
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_idx) < JOINTS))
        else $error("joint index out of range");

    // A zero-motion item carries all-zero velocities
    a_zero_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[TU_ZERO_MOVE]) |->
        (m_axis_tdata[MAXJ*POS_W-1:0] == '0))
        else $error("zero-motion item with nonzero velocity");

    // A start point leaves the block ready again in the following cycle
    a_start_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && s_axis_tuser == CMD_START) |=> s_axis_tready)
        else $error("start point did not return to idle");

    // Elapsed time only falls on a start point
    a_time_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(in_acc && s_axis_tuser == CMD_START)) |->
        (r_elapsed >= $past(r_elapsed)))
        else $error("elapsed time decreased");

    // A divide is launched only from a busy sequencer state
    a_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_state == S_DUR || r_state == S_VEL))
        else $error("divide launched outside a divide pass");

endmodule

`default_nettype wire

// ----- src/jvts_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle
module jvts_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 48
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    input  wire        [NUM_W-1:0] i_num,
    input  wire        [DEN_W-1:0] i_den,
    output jvts_pkg::t_div_stat    o_stat,
    output logic       [NUM_W-1:0] o_quot
);
    import jvts_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W+1:0] diff;
    logic             ge;

    // Trial subtract of the shifted remainder
    always_comb begin
        rem_sh = {r_rem, r_quot[NUM_W-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_den};
        ge     = ~diff[DEN_W+1];
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CNT_W'(1));
            r_busy <= (r_cnt != CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath: numerator shifts out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quot <= {r_quot[NUM_W-2:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule

`default_nettype wire
